// File: hdl/n2a_pkg.sv
// Shared types, character codes and helpers for the number-to-ASCII formatter.
package n2a_pkg;

  // Format selector codes
  typedef enum logic [2:0] {
    FUNC_DEC     = 3'd0,
    FUNC_FIXED   = 3'd1,
    FUNC_HEX8    = 3'd2,
    FUNC_HEX16   = 3'd3,
    FUNC_HEX32   = 3'd4,
    FUNC_NEWLINE = 3'd5
  } func_e;

  // How the character sequencer renders its run
  typedef enum logic [1:0] {
    MODE_DIGIT   = 2'd0,
    MODE_FIXED   = 2'd1,
    MODE_NEWLINE = 2'd2
  } emit_mode_e;

  localparam logic [7:0] ASCII_ZERO       = 8'd48;
  localparam logic [7:0] ASCII_DOT        = 8'd46;
  localparam logic [7:0] ASCII_LF         = 8'd10;
  localparam logic [7:0] ASCII_CR         = 8'd13;
  localparam logic [7:0] ASCII_HEX_OFFSET = 8'd55;

  localparam int unsigned BIN_W    = 16;             // binary width converted to decimal
  localparam int unsigned BCD_W    = 20;             // five BCD digits
  localparam int unsigned DIGITS_W = 32;             // eight nibble digits, left aligned
  localparam int unsigned COUNT_W  = 4;              // characters per run, up to 8

  // Run descriptor handed from the control to the character sequencer
  typedef struct packed {
    logic                  load;
    emit_mode_e            mode;
    logic [DIGITS_W-1:0]   digits;
    logic [COUNT_W-1:0]    count;
  } run_load_t;

  // Map one nibble to an uppercase hex or decimal character
  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'h0, nib};
    if (nib < 4'd10) begin
      nibble_char = ASCII_ZERO + ext;
    end else begin
      nibble_char = ASCII_HEX_OFFSET + ext;
    end
  endfunction

endpackage

// File: hdl/n2a_bcd.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module n2a_bcd (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [n2a_pkg::BIN_W-1:0]     value_i,
  output logic                          done_o,
  output logic [n2a_pkg::BCD_W-1:0]     bcd_o
);

  localparam int unsigned NDIG  = n2a_pkg::BCD_W / 4;
  localparam int unsigned CNT_W = $clog2(n2a_pkg::BIN_W);

  logic [n2a_pkg::BIN_W-1:0] shift_q, shift_d;
  logic [n2a_pkg::BCD_W-1:0] bcd_q, bcd_d;
  logic [n2a_pkg::BCD_W-1:0] adj;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;

  // Add 3 to every digit that is 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // Load on start, then shift one bit per cycle
  always_comb begin
    shift_d = shift_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      shift_d = value_i;
      bcd_d   = '0;
      cnt_d   = CNT_W'(n2a_pkg::BIN_W - 1);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      bcd_d   = {adj[n2a_pkg::BCD_W-2:0], shift_q[n2a_pkg::BIN_W-1]};
      shift_d = {shift_q[n2a_pkg::BIN_W-2:0], 1'b0};
      cnt_d   = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    bcd_q   <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// File: hdl/n2a_emit.sv
// Character sequencer: emits nibble digits, a dot, or LF then CR to an output register.
module n2a_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  n2a_pkg::run_load_t run_i,
  output logic               busy_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         ascii_char_o,
  output logic               last_o
);

  logic [n2a_pkg::DIGITS_W-1:0] digits_q, digits_d;
  logic [n2a_pkg::COUNT_W-1:0]  remain_q, remain_d;
  n2a_pkg::emit_mode_e          mode_q, mode_d;
  logic                         valid_q, valid_d;
  logic [7:0]                   char_q, char_d;
  logic                         last_q, last_d;
  logic                         advance;
  logic                         is_dot;
  logic [7:0]                   next_char;

  assign advance = (remain_q != '0) && (!valid_q || out_ready_i);
  assign is_dot  = (mode_q == n2a_pkg::MODE_FIXED) && (remain_q == n2a_pkg::COUNT_W'(3));

  // Pick the character for the current position of the run
  always_comb begin
    if (mode_q == n2a_pkg::MODE_NEWLINE) begin
      next_char = (remain_q == n2a_pkg::COUNT_W'(2)) ? n2a_pkg::ASCII_LF : n2a_pkg::ASCII_CR;
    end else if (is_dot) begin
      next_char = n2a_pkg::ASCII_DOT;
    end else begin
      next_char = n2a_pkg::nibble_char(digits_q[n2a_pkg::DIGITS_W-1 -: 4]);
    end
  end

  // Load a run, advance it one character per transfer slot
  always_comb begin
    digits_d = digits_q;
    remain_d = remain_q;
    mode_d   = mode_q;
    valid_d  = valid_q;
    char_d   = char_q;
    last_d   = last_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (run_i.load) begin
      digits_d = run_i.digits;
      remain_d = run_i.count;
      mode_d   = run_i.mode;
    end else if (advance) begin
      valid_d  = 1'b1;
      char_d   = next_char;
      last_d   = (remain_q == n2a_pkg::COUNT_W'(1));
      remain_d = remain_q - 1'b1;
      if (!is_dot) begin
        digits_d = {digits_q[n2a_pkg::DIGITS_W-5:0], 4'h0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
      mode_q   <= n2a_pkg::MODE_DIGIT;
      valid_q  <= 1'b0;
    end else begin
      remain_q <= remain_d;
      mode_q   <= mode_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    char_q   <= char_d;
    last_q   <= last_d;
  end

  assign busy_o       = (remain_q != '0);
  assign out_valid_o  = valid_q;
  assign ascii_char_o = char_q;
  assign last_o       = last_q;

endmodule

// File: hdl/number_to_ascii_formatter_core.sv
// Top level of the number-to-ASCII formatter: input control, converter and sequencer.
//
// Input channel (in_valid_i / in_ready_o) takes one item: func_i selects the
// format and number_i carries the value. The output channel (out_valid_o /
// out_ready_i) returns the formatted text one character per transfer, with
// last_o set on the final character of the run. Unused format codes give no
// characters.
// Hex and newline runs start right away: the run descriptor is loaded into the
// sequencer registers and then the first character into the output register;
// further characters follow one per cycle while the receiver accepts them.
// Decimal and fixed-point runs first pass the low 16 bits through the
// bit-serial BCD converter, one bit per shift; its registered done flag then
// loads the run, and characters follow one per cycle as the receiver takes them.
// The next item is taken as soon as the last character of the run sits in
// the output register, so it overlaps the wait for that final transfer.
// Reset clears all control state; no output is valid after reset.
// When the receiver stalls, the output register holds its character and the
// sequencer waits; the input side stops taking items until the run drains.
module number_to_ascii_formatter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [31:0] number_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  ascii_char_o,
  output logic        last_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CONV = 2'b10
  } state_e;

  state_e                          state_q, state_d;
  logic                            fixed_q, fixed_d;
  logic                            in_xfer;
  logic                            emit_busy;
  logic                            bcd_start;
  logic                            bcd_done;
  logic [n2a_pkg::BCD_W-1:0]       bcd;
  n2a_pkg::run_load_t              run;

  assign in_ready_o = (state_q == ST_IDLE) && !emit_busy;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Decode the item and build the run descriptor
  always_comb begin
    state_d   = state_q;
    fixed_d   = fixed_q;
    bcd_start = 1'b0;
    run       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          fixed_d = (func_i == n2a_pkg::FUNC_FIXED);
          case (n2a_pkg::func_e'(func_i))
            n2a_pkg::FUNC_DEC, n2a_pkg::FUNC_FIXED: begin
              bcd_start = 1'b1;
              state_d   = ST_CONV;
            end
            n2a_pkg::FUNC_HEX8: begin
              run.load   = 1'b1;
              run.mode   = n2a_pkg::MODE_DIGIT;
              run.digits = {number_i[7:0], 24'h0};
              run.count  = n2a_pkg::COUNT_W'(2);
            end
            n2a_pkg::FUNC_HEX16: begin
              run.load   = 1'b1;
              run.mode   = n2a_pkg::MODE_DIGIT;
              run.digits = {number_i[15:0], 16'h0};
              run.count  = n2a_pkg::COUNT_W'(4);
            end
            n2a_pkg::FUNC_HEX32: begin
              run.load   = 1'b1;
              run.mode   = n2a_pkg::MODE_DIGIT;
              run.digits = number_i;
              run.count  = n2a_pkg::COUNT_W'(8);
            end
            n2a_pkg::FUNC_NEWLINE: begin
              run.load   = 1'b1;
              run.mode   = n2a_pkg::MODE_NEWLINE;
              run.count  = n2a_pkg::COUNT_W'(2);
            end
            default: begin
              run.load = 1'b0;
            end
          endcase
        end
      end
      ST_CONV: begin
        if (bcd_done) begin
          run.load = 1'b1;
          state_d  = ST_IDLE;
          if (fixed_q) begin
            // Value / 10 drops the units digit; ten-thousands shows only if nonzero
            run.mode = n2a_pkg::MODE_FIXED;
            if (bcd[19:16] != 4'h0) begin
              run.digits = {bcd[19:4], 16'h0};
              run.count  = n2a_pkg::COUNT_W'(5);
            end else begin
              run.digits = {bcd[15:4], 20'h0};
              run.count  = n2a_pkg::COUNT_W'(4);
            end
          end else begin
            // Suppress leading zeros, keep at least one digit
            run.mode = n2a_pkg::MODE_DIGIT;
            if (bcd[19:16] != 4'h0) begin
              run.digits = {bcd, 12'h0};
              run.count  = n2a_pkg::COUNT_W'(5);
            end else if (bcd[15:12] != 4'h0) begin
              run.digits = {bcd[15:0], 16'h0};
              run.count  = n2a_pkg::COUNT_W'(4);
            end else if (bcd[11:8] != 4'h0) begin
              run.digits = {bcd[11:0], 20'h0};
              run.count  = n2a_pkg::COUNT_W'(3);
            end else if (bcd[7:4] != 4'h0) begin
              run.digits = {bcd[7:0], 24'h0};
              run.count  = n2a_pkg::COUNT_W'(2);
            end else begin
              run.digits = {bcd[3:0], 28'h0};
              run.count  = n2a_pkg::COUNT_W'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fixed_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fixed_q <= fixed_d;
    end
  end

  n2a_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bcd_start),
    .value_i (number_i[n2a_pkg::BIN_W-1:0]),
    .done_o  (bcd_done),
    .bcd_o   (bcd)
  );

  n2a_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .run_i        (run),
    .busy_o       (emit_busy),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ascii_char_o (ascii_char_o),
    .last_o       (last_o)
  );

endmodule

// File: hdl/n2a_checker.sv
// Port-level checks for the number-to-ASCII formatter, bound to the top level.
module n2a_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [2:0]  func_i,
  input logic [31:0] number_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  ascii_char_o,
  input logic        last_o
);

  logic in_xfer;
  logic known_func;

  assign in_xfer    = in_valid_i && in_ready_o;
  assign known_func = (func_i <= n2a_pkg::FUNC_NEWLINE);

  // Hold a stalled character and its last marker
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ascii_char_o) && $stable(last_o))
    else $error("stalled output character changed");

  // A known format starts work, so the input side closes for the next cycle
  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && known_func |=> !in_ready_o)
    else $error("input still ready right after a formatting item");

  // An unused format code does no work and leaves the input open
  a_unused_func: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !known_func |=> in_ready_o)
    else $error("unused format code blocked the input");

  // A hex8 item shows its first character once its run is loaded into the sequencer, never as last
  a_hex8_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (func_i == n2a_pkg::FUNC_HEX8) && !(out_valid_o && !out_ready_i)
    |=> ##1 out_valid_o && !last_o)
    else $error("hex8 run did not start on time");

endmodule

bind number_to_ascii_formatter_core n2a_checker u_n2a_checker (.*);
